@@ rtl/hsv2rgb_pkg.sv @@
// Shared constants, types and helpers for the HSV to RGB pixel converter.
`default_nettype none

package hsv2rgb_pkg;

  // Fraction bits of saturation and value (supported range 6..16)
  localparam int FRAC_BITS = 10;

  localparam int HUE_W   = 9;
  localparam int FIELD_W = 10;
  localparam int CHAN_W  = 8;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam int HUE_PER_SECTOR = 60;
  localparam int SECTORS        = 6;
  localparam int CHAN_MAX       = 255;

  // hue / 60 as (hue * RECIP_60) >> RECIP_SH, exact for every 9-bit hue
  localparam int RECIP_60 = 1093;
  localparam int RECIP_SH = 16;
  localparam int RECIP_W  = 11;
  localparam int HPROD_W  = HUE_W + RECIP_W;
  localparam int QUO_W    = 4;
  localparam int REM_W    = 6;
  localparam int SECT_W   = 3;
  localparam int RS_W     = REM_W + FIELD_W;

  // Channel x = 17 * v * M / 2^(2*FRAC_BITS+2), M scaled by 60 * 2^FRAC_BITS
  localparam int M_W    = ((FRAC_BITS > FIELD_W) ? FRAC_BITS : FIELD_W) + 8;
  localparam int P_W    = M_W + FIELD_W + 1;
  localparam int N_W    = P_W + 5;
  localparam int OUT_SH = 2 * FRAC_BITS + 2;

  localparam int NUM_LANES = 4;
  localparam int LANE_V    = 0;
  localparam int LANE_P    = 1;
  localparam int LANE_Q    = 2;
  localparam int LANE_T    = 3;

  localparam logic [SECT_W-1:0] SECTOR_0 = 3'd0;
  localparam logic [SECT_W-1:0] SECTOR_1 = 3'd1;
  localparam logic [SECT_W-1:0] SECTOR_2 = 3'd2;
  localparam logic [SECT_W-1:0] SECTOR_3 = 3'd3;
  localparam logic [SECT_W-1:0] SECTOR_4 = 3'd4;

  typedef logic signed [M_W-1:0] mult_t;
  typedef logic signed [P_W-1:0] prod_t;
  typedef logic [CHAN_W-1:0]     chan_t;

  localparam mult_t M_FULL = mult_t'(HUE_PER_SECTOR) <<< FRAC_BITS;

  // Scale by 17, drop the fraction, clamp to 0..255
  function automatic chan_t chan_clamp(input prod_t p);
    logic signed [N_W-1:0] n;
    logic signed [N_W-1:0] sh;
    n  = N_W'(p);
    n  = (n <<< 4) + n;
    sh = n >>> OUT_SH;
    if (n <= 0) begin
      chan_clamp = '0;
    end else if (sh > $signed(N_W'(CHAN_MAX))) begin
      chan_clamp = chan_t'(CHAN_MAX);
    end else begin
      chan_clamp = sh[CHAN_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/hsv_to_rgb_converter.sv @@
// HSV to RGB pixel converter: five-stage pipeline, one pixel per clock unless stalled.
//
// Usage:
//   Input words arrive on the in_ channel, one pixel per word: hue in whole
//   degrees and saturation and value as unsigned fractions of 2^FRAC_BITS.
//   Each accepted word yields exactly one output word on the out_ channel
//   carrying 8-bit red, green and blue, in the order the pixels came in.
//   The accepting edge loads the first stage; the word then passes the
//   remainder, helper-term, multiply and output registers to out_tvalid.
//   Throughput: one word per clock, set by the five register stages
//   (sector split, remainder, helper terms, value multiply, scale and route).
//   Each stage holds only while the stage after it is full and stalled, so
//   a stall at the output closes bubbles first and in_tready stays high
//   until all five stages are full; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) empties every stage; in_tready is high
//   from the first cycle after reset.
`default_nettype none

module hsv_to_rgb_converter (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [8:0] hue, [18:9] saturation, [28:19] brightness, [31:29] zero
  input  wire logic [hsv2rgb_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [hsv2rgb_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import hsv2rgb_pkg::*;

  // Stage enables: a stage advances when it is empty or the next one moves
  logic en0, en1, en2, en3, en4;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;

  // Input field unpacking
  logic [HUE_W-1:0]   in_hue;
  logic [FIELD_W-1:0] in_sat;
  logic [FIELD_W-1:0] in_bri;

  assign in_hue = in_tdata[HUE_W-1:0];
  assign in_sat = in_tdata[HUE_W +: FIELD_W];
  assign in_bri = in_tdata[HUE_W+FIELD_W +: FIELD_W];

  assign en4 = !out_vld_r || out_tready;
  assign en3 = !s4_vld_r || en4;
  assign en2 = !s3_vld_r || en3;
  assign en1 = !s2_vld_r || en2;
  assign en0 = !s1_vld_r || en1;

  assign in_tready = en0;

  // Valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en0) begin
        s1_vld_r <= in_tvalid;
      end
      if (en1) begin
        s2_vld_r <= s1_vld_r;
      end
      if (en2) begin
        s3_vld_r <= s2_vld_r;
      end
      if (en3) begin
        s4_vld_r <= s3_vld_r;
      end
      if (en4) begin
        out_vld_r <= s4_vld_r;
      end
    end
  end

  // Stage 1: quotient hue / 60 by reciprocal multiply
  logic [HPROD_W-1:0] hprod;
  logic [QUO_W-1:0]   s1_quo_nxt, s1_quo_r;
  logic [HUE_W-1:0]   s1_hue_r;
  logic [FIELD_W-1:0] s1_sat_r, s1_bri_r;

  assign hprod      = HPROD_W'(in_hue) * HPROD_W'(RECIP_60);
  assign s1_quo_nxt = hprod[RECIP_SH +: QUO_W];

  // Stage 2: remainder within the sector, sector wrapped to 0..5
  logic [HUE_W-1:0]   quo_x60;
  logic [REM_W-1:0]   s2_rem_nxt, s2_rem_r;
  logic [SECT_W-1:0]  s2_sec_nxt, s2_sec_r;
  logic [FIELD_W-1:0] s2_sat_r, s2_bri_r;

  assign quo_x60    = HUE_W'(s1_quo_r * HUE_W'(HUE_PER_SECTOR));
  assign s2_rem_nxt = REM_W'(s1_hue_r - quo_x60);
  assign s2_sec_nxt = (s1_quo_r >= QUO_W'(SECTORS)) ? SECT_W'(s1_quo_r - QUO_W'(SECTORS))
                                                     : SECT_W'(s1_quo_r);

  // Stage 3: helper terms M for v, p, q and t
  logic [RS_W-1:0]    rs, crs, s60;
  logic [REM_W-1:0]   crem;
  mult_t              s3_m_nxt [NUM_LANES];
  mult_t              s3_m_r   [NUM_LANES];
  logic [SECT_W-1:0]  s3_sec_r;
  logic [FIELD_W-1:0] s3_bri_r;

  assign crem = REM_W'(HUE_PER_SECTOR) - s2_rem_r;
  assign rs   = RS_W'(s2_rem_r) * RS_W'(s2_sat_r);
  assign crs  = RS_W'(crem) * RS_W'(s2_sat_r);
  assign s60  = RS_W'(HUE_PER_SECTOR) * RS_W'(s2_sat_r);

  assign s3_m_nxt[LANE_V] = M_FULL;
  assign s3_m_nxt[LANE_P] = M_FULL - mult_t'(s60);
  assign s3_m_nxt[LANE_Q] = M_FULL - mult_t'(rs);
  assign s3_m_nxt[LANE_T] = M_FULL - mult_t'(crs);

  // Stage 4: multiply each term by the value
  prod_t              s4_p_nxt [NUM_LANES];
  prod_t              s4_p_r   [NUM_LANES];
  logic [SECT_W-1:0]  s4_sec_r;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    assign s4_p_nxt[g] = prod_t'(s3_m_r[g]) * prod_t'($signed({1'b0, s3_bri_r}));
  end

  // Stage 5: scale, clamp and route by sector
  chan_t cv, cp, cq, ct;
  chan_t red_nxt, green_nxt, blue_nxt;
  chan_t red_r, green_r, blue_r;

  assign cv = chan_clamp(s4_p_r[LANE_V]);
  assign cp = chan_clamp(s4_p_r[LANE_P]);
  assign cq = chan_clamp(s4_p_r[LANE_Q]);
  assign ct = chan_clamp(s4_p_r[LANE_T]);

  always_comb begin
    case (s4_sec_r)
      SECTOR_0: begin
        red_nxt = cv; green_nxt = ct; blue_nxt = cp;
      end
      SECTOR_1: begin
        red_nxt = cq; green_nxt = cv; blue_nxt = cp;
      end
      SECTOR_2: begin
        red_nxt = cp; green_nxt = cv; blue_nxt = ct;
      end
      SECTOR_3: begin
        red_nxt = cp; green_nxt = cq; blue_nxt = cv;
      end
      SECTOR_4: begin
        red_nxt = ct; green_nxt = cp; blue_nxt = cv;
      end
      default: begin
        red_nxt = cv; green_nxt = cp; blue_nxt = cq;
      end
    endcase
  end

  // Payload registers: load when the stage advances, hold otherwise
  always_ff @(posedge clk) begin
    if (en0) begin
      s1_quo_r <= s1_quo_nxt;
      s1_hue_r <= in_hue;
      s1_sat_r <= in_sat;
      s1_bri_r <= in_bri;
    end
    if (en1) begin
      s2_rem_r <= s2_rem_nxt;
      s2_sec_r <= s2_sec_nxt;
      s2_sat_r <= s1_sat_r;
      s2_bri_r <= s1_bri_r;
    end
    if (en2) begin
      s3_m_r   <= s3_m_nxt;
      s3_sec_r <= s2_sec_r;
      s3_bri_r <= s2_bri_r;
    end
    if (en3) begin
      s4_p_r   <= s4_p_nxt;
      s4_sec_r <= s3_sec_r;
    end
    if (en4) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {blue_r, green_r, red_r};

endmodule

`default_nettype wire
